// ----- design/sdr_pkg.sv -----
// Shared types and constants for the stream duplicate remover.
package sdr_pkg;

    localparam int TABLE_DEPTH_DEFAULT = 256;
    localparam int DATA_W              = 32;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_FINISH
    } sdr_state_t;

    // Commands from the controller to the datapath
    typedef struct packed {
        logic accept;   // capture the incoming item and start a new search
        logic rd;       // read the table entry at the scan index and advance it
        logic commit;   // store a new value if room, load the result register
    } sdr_cmd_t;

    // Status from the datapath to the controller
    typedef struct packed {
        logic more;     // scan index still below the fill count
        logic rd_pend;  // a table read issued last cycle is being compared now
        logic match;    // that read equals the held value
        logic out_free; // result register can take a new item this cycle
    } sdr_status_t;

endpackage

// ----- design/sdr_ctrl.sv -----
// Controller state machine for the stream duplicate remover.
module sdr_ctrl
    import sdr_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        item_valid,
    output logic        item_stall,
    input  sdr_status_t status,
    output sdr_cmd_t    cmd
);

    sdr_state_t state_reg;
    sdr_state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        item_stall = 1'b1;
        case (state_reg)
            ST_IDLE:
            begin
                item_stall = 1'b0;
                if (item_valid)
                begin
                    cmd.accept = 1'b1;
                    state_next = ST_SCAN;
                end
            end
            ST_SCAN:
            begin
                if (status.match)
                begin
                    state_next = ST_FINISH;
                end
                else if (status.more)
                begin
                    cmd.rd = 1'b1;
                end
                else if (!status.rd_pend)
                begin
                    state_next = ST_FINISH;
                end
            end
            ST_FINISH:
            begin
                // hold here while the previous result is still stalled
                if (status.out_free)
                begin
                    cmd.commit = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

// ----- design/sdr_datapath.sv -----
// Datapath for the stream duplicate remover: table memory, scan and result register.
module sdr_datapath
    import sdr_pkg::*;
#(
    parameter int TABLE_DEPTH = TABLE_DEPTH_DEFAULT
)
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  sdr_cmd_t                 cmd,
    output sdr_status_t              status,
    input  logic                     first_of_set,
    input  logic signed [DATA_W-1:0] value,
    input  logic                     last_of_set,
    output logic signed [DATA_W-1:0] value_out,
    output logic                     kept,
    output logic                     overflow,
    output logic                     last_out,
    output logic                     result_valid,
    input  logic                     result_stall
);

    localparam int CW = $clog2(TABLE_DEPTH + 1);
    localparam int AW = $clog2(TABLE_DEPTH);
    localparam logic [CW-1:0] DEPTH_C = CW'(TABLE_DEPTH);

    logic [DATA_W-1:0] mem [TABLE_DEPTH];

    logic [CW-1:0]     count_reg;
    logic [CW-1:0]     idx_reg;
    logic              rd_pend_reg;
    logic              found_reg;
    logic [DATA_W-1:0] rdata_reg;
    logic [DATA_W-1:0] value_reg;
    logic              last_reg;

    logic              result_valid_reg;
    logic [DATA_W-1:0] value_out_reg;
    logic              kept_reg;
    logic              overflow_reg;
    logic              last_out_reg;

    logic              match;
    logic              full;
    logic              is_new;
    logic              out_free;

    assign match    = rd_pend_reg && (rdata_reg == value_reg);
    assign full     = (count_reg == DEPTH_C);
    assign is_new   = !found_reg;
    assign out_free = !result_valid_reg || !result_stall;

    assign status.more     = (idx_reg < count_reg);
    assign status.rd_pend  = rd_pend_reg;
    assign status.match    = match;
    assign status.out_free = out_free;

    // table memory: one read port for the scan, one write for the append
    always_ff @(posedge clk)
    begin
        if (cmd.rd)
        begin
            rdata_reg <= mem[idx_reg[AW-1:0]];
        end
        if (cmd.commit && is_new && !full)
        begin
            mem[count_reg[AW-1:0]] <= value_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.accept)
        begin
            value_reg <= value;
            last_reg  <= last_of_set;
        end
        if (cmd.commit)
        begin
            value_out_reg <= value_reg;
            kept_reg      <= is_new && !full;
            overflow_reg  <= is_new && full;
            last_out_reg  <= last_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg        <= '0;
            idx_reg          <= '0;
            rd_pend_reg      <= 1'b0;
            found_reg        <= 1'b0;
            result_valid_reg <= 1'b0;
        end
        else
        begin
            rd_pend_reg <= cmd.rd;
            if (cmd.accept)
            begin
                idx_reg   <= '0;
                found_reg <= 1'b0;
                // drop the previous set before the search starts
                if (first_of_set)
                begin
                    count_reg <= '0;
                end
            end
            else
            begin
                if (cmd.rd)
                begin
                    idx_reg <= idx_reg + 1'b1;
                end
                if (match)
                begin
                    found_reg <= 1'b1;
                end
            end
            if (cmd.commit && is_new && !full)
            begin
                count_reg <= count_reg + 1'b1;
            end
            if (cmd.commit)
            begin
                result_valid_reg <= 1'b1;
            end
            else if (!result_stall)
            begin
                result_valid_reg <= 1'b0;
            end
        end
    end

    assign result_valid = result_valid_reg;
    assign value_out    = value_out_reg;
    assign kept         = kept_reg;
    assign overflow     = overflow_reg;
    assign last_out     = last_out_reg;

endmodule

// ----- design/stream_duplicate_remover_core.sv -----
// Stream duplicate remover: keeps the first occurrence of each value in a set.
//
// Input channel (item_valid / item_stall) carries first_of_set, value and
// last_of_set. first_of_set empties the table of distinct values before the
// item is searched. Output channel (result_valid / result_stall) returns one
// result per item: value_out, kept, overflow and last_out.
//
// Each item is searched against the filled table entries, one entry read per
// cycle from the table memory (one read port, one write port) with registered
// read data, which is compared with the held value. A match ends the scan;
// else it ends once every filled entry has been read and compared. The
// finish state then loads the result register when it is free, and a new
// item is accepted the cycle after a result is loaded.
//
// A new value is appended and flagged kept; with the table full it is flagged
// overflow and not stored. Reset empties the table at once (fill count zero).
// A finished result waits in the output register while the receiver stalls;
// the next item is still accepted and searched, and only holds at its finish
// until the output register is free.
module stream_duplicate_remover_core
    import sdr_pkg::*;
#(
    parameter int TABLE_DEPTH = TABLE_DEPTH_DEFAULT
)
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     item_valid,
    output logic                     item_stall,
    input  logic                     first_of_set,
    input  logic signed [DATA_W-1:0] value,
    input  logic                     last_of_set,
    output logic                     result_valid,
    input  logic                     result_stall,
    output logic signed [DATA_W-1:0] value_out,
    output logic                     kept,
    output logic                     overflow,
    output logic                     last_out
);

    sdr_cmd_t    cmd;
    sdr_status_t status;

    sdr_ctrl u_ctrl (
        .clk        (clk),
        .rst_n      (rst_n),
        .item_valid (item_valid),
        .item_stall (item_stall),
        .status     (status),
        .cmd        (cmd)
    );

    sdr_datapath #(
        .TABLE_DEPTH (TABLE_DEPTH)
    ) u_datapath (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (cmd),
        .status       (status),
        .first_of_set (first_of_set),
        .value        (value),
        .last_of_set  (last_of_set),
        .value_out    (value_out),
        .kept         (kept),
        .overflow     (overflow),
        .last_out     (last_out),
        .result_valid (result_valid),
        .result_stall (result_stall)
    );

endmodule
